[sv/ebw_pkg.sv]
// ----------------------------------------------------------------------------
// ebw_pkg
// Shared constants, types and arithmetic helpers for the body-to-world
// acceleration rotation pipeline.
// ----------------------------------------------------------------------------
package ebw_pkg;

   localparam int AngW   = 16;
   localparam int AccW   = 20;
   localparam int GravW  = 15;
   localparam logic [GravW-1:0] GravReset = 15'd10045;

   // pipeline depth: sine/cosine series, then matrix product
   localparam int SinLat  = 7;
   localparam int MatLat  = 4;
   localparam int Latency = SinLat + MatLat;

   // Q30 quantities: residue, sine/cosine and matrix entries
   localparam int QW = 33;
   localparam logic signed [QW-1:0] HalfPi  = 33'sd1686629713;
   localparam logic signed [QW-1:0] QuartPi = 33'sd843314856;
   localparam logic signed [QW-1:0] Q30One  = 33'sd1073741824;

   // reciprocals for truncating division of a magnitude below 2^30:
   // shift is 30 plus the bits of the divisor, multiplier rounded up
   localparam int RecipSh6     = 33;
   localparam int RecipSh24    = 35;
   localparam int RecipSh120   = 37;
   localparam int RecipSh720   = 40;
   localparam int RecipSh5040  = 43;
   localparam int RecipSh40320 = 46;
   localparam logic [30:0] RecipM6     = 31'(((64'd1 << 33) + 64'd5) / 64'd6);
   localparam logic [30:0] RecipM24    = 31'(((64'd1 << 35) + 64'd23) / 64'd24);
   localparam logic [30:0] RecipM120   = 31'(((64'd1 << 37) + 64'd119) / 64'd120);
   localparam logic [30:0] RecipM720   = 31'(((64'd1 << 40) + 64'd719) / 64'd720);
   localparam logic [30:0] RecipM5040  = 31'(((64'd1 << 43) + 64'd5039) / 64'd5040);
   localparam logic [30:0] RecipM40320 = 31'(((64'd1 << 46) + 64'd40319) / 64'd40320);

   typedef logic signed [QW-1:0] q30_type;

   // Sign-magnitude product of two Q30 values, rounded, ties away from zero
   function automatic q30_type mul_q30(input q30_type a, input q30_type b);
      logic [QW-1:0] ua;
      logic [QW-1:0] ub;
      logic [2*QW-1:0] p;
      logic neg;
      neg = a[QW-1] ^ b[QW-1];
      ua  = a[QW-1] ? QW'(-a) : QW'(a);
      ub  = b[QW-1] ? QW'(-b) : QW'(b);
      p   = (2*QW)'(ua) * (2*QW)'(ub);
      p   = (p + (2*QW)'(64'd1 << 29)) >> 30;
      mul_q30 = neg ? -q30_type'(p[QW-1:0]) : q30_type'(p[QW-1:0]);
   endfunction

   // Division by a constant, truncated toward zero, via reciprocal multiply
   function automatic q30_type div_recip(input q30_type x, input logic [30:0] m,
                                         input int sh);
      logic [29:0] ux;
      logic [60:0] p;
      logic [29:0] q;
      ux = x[QW-1] ? 30'(-x) : 30'(x);
      p  = 61'(ux) * 61'(m);
      q  = 30'(p >> sh);
      div_recip = x[QW-1] ? -q30_type'(q) : q30_type'(q);
   endfunction

endpackage

[sv/euler_body_to_world_accel.sv]
// ----------------------------------------------------------------------------
// euler_body_to_world_accel
// Rotates a body-frame acceleration into the world frame (ZYX Euler matrix).
// ----------------------------------------------------------------------------
// A fully pipelined unit taking one sample per cycle, through the sine/cosine
// series and then the matrix product; the whole pipe advances while the
// output is not stalled, so a stall on the result side holds every stage.
// Gravity offset is written through the csr port and should only change
// while the pipe is empty.
module euler_body_to_world_accel
   import ebw_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [AngW-1:0]  req_roll_in,
   input  logic signed [AngW-1:0]  req_pitch_in,
   input  logic signed [AngW-1:0]  req_yaw_in,
   input  logic signed [AccW-1:0]  req_accel_body_x,
   input  logic signed [AccW-1:0]  req_accel_body_y,
   input  logic signed [AccW-1:0]  req_accel_body_z,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [AngW-1:0]  rsp_roll_out,
   output logic signed [AngW-1:0]  rsp_pitch_out,
   output logic signed [AngW-1:0]  rsp_yaw_out,
   output logic signed [AccW-1:0]  rsp_accel_world_x,
   output logic signed [AccW-1:0]  rsp_accel_world_y,
   output logic signed [AccW-1:0]  rsp_accel_world_z,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [GravW-1:0]        csr_gravity_offset
);

   logic en;
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;
   assign csr_ready = 1'b1;

   // gravity offset register
   logic [GravW-1:0] grav_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         grav_ff <= GravReset;
      end else if (csr_valid && csr_ready) begin
         grav_ff <= csr_gravity_offset;
      end
   end

   // valid bits travelling with the data
   logic [Latency-1:0] vld_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[Latency-2:0], req_valid};
      end
   end
   assign rsp_valid = vld_ff[Latency-1];

   // sine/cosine units
   q30_type sf, cf, st, ct, sp, cp;
   ebw_sincos u_roll  (.clock, .en, .ang(-(AngW+1)'(req_roll_in)),
                       .sin_q(sf), .cos_q(cf));
   ebw_sincos u_pitch (.clock, .en, .ang(-(AngW+1)'(req_pitch_in)),
                       .sin_q(st), .cos_q(ct));
   ebw_sincos u_yaw   (.clock, .en, .ang((AngW+1)'(req_yaw_in)),
                       .sin_q(sp), .cos_q(cp));

   // delay line for angles and body acceleration
   logic signed [AngW-1:0] ro_ff [Latency], pi_ff [Latency], ya_ff [Latency];
   logic signed [AccW-1:0] ax_ff [SinLat], ay_ff [SinLat], az_ff [SinLat];
   always_ff @(posedge clock) begin
      if (en) begin
         ro_ff[0] <= req_roll_in;
         pi_ff[0] <= req_pitch_in;
         ya_ff[0] <= req_yaw_in;
         for (int i = 1; i < Latency; i++) begin
            ro_ff[i] <= ro_ff[i-1];
            pi_ff[i] <= pi_ff[i-1];
            ya_ff[i] <= ya_ff[i-1];
         end
         ax_ff[0] <= req_accel_body_x;
         ay_ff[0] <= req_accel_body_y;
         az_ff[0] <= req_accel_body_z;
         for (int i = 1; i < SinLat; i++) begin
            ax_ff[i] <= ax_ff[i-1];
            ay_ff[i] <= ay_ff[i-1];
            az_ff[i] <= az_ff[i-1];
         end
      end
   end

   ebw_matrix u_matrix (
      .clock, .en,
      .sf, .cf, .st, .ct, .sp, .cp,
      .ax(ax_ff[SinLat-1]), .ay(ay_ff[SinLat-1]), .az(az_ff[SinLat-1]),
      .grav(grav_ff),
      .wx(rsp_accel_world_x), .wy(rsp_accel_world_y), .wz(rsp_accel_world_z)
   );

   assign rsp_roll_out  = ro_ff[Latency-1];
   assign rsp_pitch_out = pi_ff[Latency-1];
   assign rsp_yaw_out   = ya_ff[Latency-1];

   // a stalled result holds while input is held off
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_accel_world_z))
      else $error("stalled result changed");

   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output backpressure");

   a_valid_flow: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall || !rsp_valid |=> rsp_valid == $past(vld_ff[Latency-2]))
      else $error("valid pipe mismatch");

endmodule

[sv/ebw_sincos.sv]
// ----------------------------------------------------------------------------
// ebw_sincos
// Pipelined Q30 sine/cosine of a Q3.13 angle: range reduction, powers by
// rounded products, Taylor series, quadrant swap. Seven register stages.
// ----------------------------------------------------------------------------
module ebw_sincos
   import ebw_pkg::*;
(
   input  logic                    clock,
   input  logic                    en,
   input  logic signed [AngW:0]    ang,
   output q30_type                 sin_q,
   output q30_type                 cos_q
);

   localparam int RW = 34;

   // stage 1: range reduction
   logic signed [RW-1:0] r0;
   logic signed [RW-1:0] rr;
   logic [1:0]           kk;
   q30_type              r_ff;
   logic [1:0]           k_ff;

   always_comb begin
      r0 = RW'(ang) <<< 17;
      rr = r0;
      kk = 2'd0;
      for (int i = 0; i < 3; i++) begin
         if (rr > RW'(QuartPi)) begin
            rr = rr - RW'(HalfPi);
            kk = kk + 2'd1;
         end else if (rr < -RW'(QuartPi)) begin
            rr = rr + RW'(HalfPi);
            kk = kk - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff <= q30_type'(rr);
         k_ff <= kk;
      end
   end

   // stage 2: r^2
   q30_type r_2ff, r2_2ff;
   logic [1:0] k_2ff;
   always_ff @(posedge clock) begin
      if (en) begin
         r_2ff  <= r_ff;
         r2_2ff <= mul_q30(r_ff, r_ff);
         k_2ff  <= k_ff;
      end
   end

   // stage 3: r^3, r^4
   q30_type r_3ff, r2_3ff, r3_3ff, r4_3ff;
   logic [1:0] k_3ff;
   always_ff @(posedge clock) begin
      if (en) begin
         r_3ff  <= r_2ff;
         r2_3ff <= r2_2ff;
         r3_3ff <= mul_q30(r2_2ff, r_2ff);
         r4_3ff <= mul_q30(r2_2ff, r2_2ff);
         k_3ff  <= k_2ff;
      end
   end

   // stage 4: r^5, r^6, r^8
   q30_type r_4ff, r2_4ff, r3_4ff, r4_4ff, r5_4ff, r6_4ff, r8_4ff;
   logic [1:0] k_4ff;
   always_ff @(posedge clock) begin
      if (en) begin
         r_4ff  <= r_3ff;
         r2_4ff <= r2_3ff;
         r3_4ff <= r3_3ff;
         r4_4ff <= r4_3ff;
         r5_4ff <= mul_q30(r3_3ff, r2_3ff);
         r6_4ff <= mul_q30(r4_3ff, r2_3ff);
         r8_4ff <= mul_q30(r4_3ff, r4_3ff);
         k_4ff  <= k_3ff;
      end
   end

   // stage 5: r^7 and the series quotients
   q30_type r_5ff, r7_5ff, q2_5ff, q3_5ff, q4_5ff, q5_5ff, q6_5ff, q8_5ff;
   logic [1:0] k_5ff;
   always_ff @(posedge clock) begin
      if (en) begin
         r_5ff  <= r_4ff;
         r7_5ff <= mul_q30(r5_4ff, r2_4ff);
         q2_5ff <= r2_4ff / 2;
         q3_5ff <= div_recip(r3_4ff, RecipM6, RecipSh6);
         q4_5ff <= div_recip(r4_4ff, RecipM24, RecipSh24);
         q5_5ff <= div_recip(r5_4ff, RecipM120, RecipSh120);
         q6_5ff <= div_recip(r6_4ff, RecipM720, RecipSh720);
         q8_5ff <= div_recip(r8_4ff, RecipM40320, RecipSh40320);
         k_5ff  <= k_4ff;
      end
   end

   // stage 6: last sine quotient, series sums
   q30_type s_part_6ff, q7_6ff, c_6ff;
   logic [1:0] k_6ff;
   always_ff @(posedge clock) begin
      if (en) begin
         s_part_6ff <= r_5ff - q3_5ff + q5_5ff;
         q7_6ff     <= div_recip(r7_5ff, RecipM5040, RecipSh5040);
         c_6ff      <= Q30One - q2_5ff + q4_5ff - q6_5ff + q8_5ff;
         k_6ff      <= k_5ff;
      end
   end

   // stage 7: finish sine, quadrant mapping
   q30_type s_full;
   q30_type sin_ff, cos_ff;
   assign s_full = s_part_6ff - q7_6ff;

   always_ff @(posedge clock) begin
      if (en) begin
         unique case (k_6ff)
            2'd0: begin sin_ff <= s_full;  cos_ff <= c_6ff;   end
            2'd1: begin sin_ff <= c_6ff;   cos_ff <= -s_full; end
            2'd2: begin sin_ff <= -s_full; cos_ff <= -c_6ff;  end
            default: begin sin_ff <= -c_6ff; cos_ff <= s_full; end
         endcase
      end
   end

   assign sin_q = sin_ff;
   assign cos_q = cos_ff;

endmodule

[sv/ebw_matrix.sv]
// ----------------------------------------------------------------------------
// ebw_matrix
// Builds the nine Q30 rotation entries from the sines and cosines and
// applies them to the body vector, adding the gravity offset to z, rounding
// and saturating to Q10.10. Four register stages.
// ----------------------------------------------------------------------------
module ebw_matrix
   import ebw_pkg::*;
(
   input  logic                    clock,
   input  logic                    en,
   input  q30_type                 sf, cf, st, ct, sp, cp,
   input  logic signed [AccW-1:0]  ax, ay, az,
   input  logic [GravW-1:0]        grav,
   output logic signed [AccW-1:0]  wx, wy, wz
);

   localparam int PW = AccW + QW;
   localparam int SW = PW + 2;

   // stage 1: pair products
   q30_type sfst_ff, cfst_ff, cfsp_ff, sfsp_ff, cfcp_ff, sfcp_ff;
   q30_type ctcp_ff, ctsp_ff, sfct_ff, cfct_ff, nst_ff, cp1_ff, sp1_ff;
   logic signed [AccW-1:0] ax1_ff, ay1_ff, az1_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         sfst_ff <= mul_q30(sf, st);
         cfst_ff <= mul_q30(cf, st);
         cfsp_ff <= mul_q30(cf, sp);
         sfsp_ff <= mul_q30(sf, sp);
         cfcp_ff <= mul_q30(cf, cp);
         sfcp_ff <= mul_q30(sf, cp);
         ctcp_ff <= mul_q30(ct, cp);
         ctsp_ff <= mul_q30(ct, sp);
         sfct_ff <= mul_q30(sf, ct);
         cfct_ff <= mul_q30(cf, ct);
         nst_ff  <= -st;
         cp1_ff  <= cp;
         sp1_ff  <= sp;
         ax1_ff  <= ax; ay1_ff <= ay; az1_ff <= az;
      end
   end

   // stage 2: triple products and entries
   q30_type m_ff [9];
   logic signed [AccW-1:0] ax2_ff, ay2_ff, az2_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         m_ff[0] <= ctcp_ff;
         m_ff[1] <= mul_q30(sfst_ff, cp1_ff) - cfsp_ff;
         m_ff[2] <= sfsp_ff + mul_q30(cfst_ff, cp1_ff);
         m_ff[3] <= ctsp_ff;
         m_ff[4] <= cfcp_ff + mul_q30(sfst_ff, sp1_ff);
         m_ff[5] <= mul_q30(cfst_ff, sp1_ff) - sfcp_ff;
         m_ff[6] <= nst_ff;
         m_ff[7] <= sfct_ff;
         m_ff[8] <= cfct_ff;
         ax2_ff <= ax1_ff; ay2_ff <= ay1_ff; az2_ff <= az1_ff;
      end
   end

   // stage 3: vector products
   logic signed [PW-1:0] p_ff [9];
   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < 3; r++) begin
            p_ff[3*r]   <= PW'(ax2_ff) * PW'(m_ff[3*r]);
            p_ff[3*r+1] <= PW'(ay2_ff) * PW'(m_ff[3*r+1]);
            p_ff[3*r+2] <= PW'(az2_ff) * PW'(m_ff[3*r+2]);
         end
      end
   end

   // stage 4: sum, round, offset, saturate
   logic signed [SW-1:0] sum [3];
   logic [SW-1:0]        mag [3];
   logic signed [SW-1:0] rnd [3];
   logic signed [AccW-1:0] w_in [3];
   logic signed [AccW-1:0] w_ff [3];

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         sum[r] = SW'(p_ff[3*r]) + SW'(p_ff[3*r+1]) - SW'(p_ff[3*r+2]);
         mag[r] = sum[r][SW-1] ? SW'(-sum[r]) : SW'(sum[r]);
         mag[r] = (mag[r] + (SW'(1) << 29)) >> 30;
         rnd[r] = sum[r][SW-1] ? -$signed(mag[r]) : $signed(mag[r]);
         if (r == 2) rnd[r] = rnd[r] + $signed(SW'(grav));
         if (rnd[r] > SW'(524287))       w_in[r] = AccW'(524287);
         else if (rnd[r] < -SW'(524288)) w_in[r] = AccW'(-524288);
         else                            w_in[r] = AccW'(rnd[r]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < 3; r++) w_ff[r] <= w_in[r];
      end
   end

   assign wx = w_ff[0];
   assign wy = w_ff[1];
   assign wz = w_ff[2];

endmodule
